@@ design/assert_macros.svh @@
// Shared assertion macros for the search unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KNN_ASSERT_IMP(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |-> (c)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define KNN_ASSERT_NXT(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

@@ design/knn_pkg.sv @@
`default_nettype none
package knn_pkg;
  localparam int MAX_NEIGHBORS = 16;
  localparam int MAX_FEATURES  = 64;
  localparam int POS_W   = $clog2(MAX_FEATURES);
  localparam int BIDX_W  = $clog2(MAX_NEIGHBORS);
  localparam int CNT_W   = BIDX_W + 1;
  localparam int IDX_W   = 16;
  localparam int DIST_W  = 38;
  localparam int ROOT_W  = 19;
  localparam int KEY_W   = DIST_W + IDX_W;
  localparam int FEAT_W  = 16;
  localparam int K_W     = 5;
  localparam int NF_W    = 7;

  // Register byte-address bit that selects the register.
  localparam logic REG_K  = 1'b0;
  localparam logic REG_NF = 1'b1;

  // Item modes.
  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  typedef logic [KEY_W-1:0] key_t;
endpackage
`default_nettype wire

@@ design/knn_in_if.sv @@
`default_nettype none
interface knn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [15:0] feature_value;
  modport source (output valid, mode, feature_value, input ready);
  modport sink (input valid, mode, feature_value, output ready);
endinterface
`default_nettype wire

@@ design/knn_out_if.sv @@
`default_nettype none
interface knn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] neighbor_index;
  logic [18:0] neighbor_distance;
  logic        last_result;
  modport source (output valid, neighbor_index, neighbor_distance, last_result,
                  input ready);
  modport sink (input valid, neighbor_index, neighbor_distance, last_result,
                output ready);
endinterface
`default_nettype wire

@@ design/knn_ram.sv @@
`default_nettype none
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/brute_force_knn_search_unit.sv @@
// Brute-force k-nearest-neighbor search. A query word is stored at once, and a
// dataset word passes a query memory read, a multiply and an accumulate. At
// the last word of a point, a list with room takes the point at once. A full
// list is scanned for its worst entry, which is then replaced if the new point
// is closer. A finish word produces each neighbor by one selection pass over the
// list memory and a 19-step square root, then waits until the word is taken;
// with an empty list it produces no result and only clears the point state.
// The block accepts no input word while a result is outstanding.
`default_nettype none
`include "assert_macros.svh"
module brute_force_knn_search_unit
  import knn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  knn_in_if.sink           in_ch,
  knn_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_QRD, S_ACC, S_ISCAN, S_IWR, S_ESCAN, S_SQRT, S_OUT
  } state_t;

  state_t            state_r;
  logic [K_W-1:0]    k_r;
  logic [NF_W-1:0]   nf_r;
  logic [POS_W-1:0]  pos_r;
  logic [IDX_W-1:0]  pcnt_r;
  logic [DIST_W-1:0] rdist_r;
  logic [CNT_W-1:0]  held_r;
  logic signed [FEAT_W-1:0] fv_r;
  logic              pend_r;
  logic [IDX_W-1:0]  ins_idx_r;
  logic [DIST_W-1:0] ins_dist_r;
  logic [CNT_W-1:0]  scan_r;
  logic              rv_r;
  logic [BIDX_W-1:0] ri_r;
  key_t              sel_key_r;
  logic [BIDX_W-1:0] sel_i_r;
  logic              found_r;
  key_t              prev_key_r;
  logic              have_prev_r;
  logic [CNT_W-1:0]  emit_r;
  logic [CNT_W-1:0]  e_r;
  logic [DIST_W-1:0] sq_v_r;
  logic [ROOT_W+2:0] sq_rem_r;
  logic [ROOT_W-1:0] sq_root_r;
  logic [4:0]        sq_step_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [ROOT_W-1:0] out_dist_r;
  logic              out_last_r;

  // Effective feature count and k.
  logic [NF_W-1:0]  nf_eff;
  logic [CNT_W-1:0] k_eff;
  always_comb begin
    if (nf_r == '0) nf_eff = NF_W'(1);
    else if (nf_r > NF_W'(MAX_FEATURES)) nf_eff = NF_W'(MAX_FEATURES);
    else nf_eff = nf_r;
    if (k_r == '0) k_eff = CNT_W'(1);
    else if (k_r > K_W'(MAX_NEIGHBORS)) k_eff = CNT_W'(MAX_NEIGHBORS);
    else k_eff = CNT_W'(k_r);
  end

  // Input handshake and the position of this word in the point.
  logic in_acc;
  logic [POS_W-1:0] pos_eff;
  logic [NF_W-1:0]  pos_inc;
  logic             pos_wrap;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign pos_eff = (NF_W'(pos_r) >= nf_eff) ? '0 : pos_r;
  assign pos_inc = NF_W'(pos_eff) + NF_W'(1);
  assign pos_wrap = (pos_inc >= nf_eff);

  // Query memory.
  logic [FEAT_W-1:0] q_rdata;
  knn_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_FEATURES)) u_qram (
    .clk(clk),
    .we(in_acc && in_ch.mode == MODE_QUERY),
    .waddr(pos_eff),
    .wdata(in_ch.feature_value),
    .raddr(pos_eff),
    .rdata_r(q_rdata)
  );

  // Neighbor list memory holds {distance, index}.
  logic              b_we;
  logic [BIDX_W-1:0] b_waddr;
  key_t              b_wdata;
  key_t              b_rdata;
  knn_ram #(.WIDTH(KEY_W), .DEPTH(MAX_NEIGHBORS)) u_bram (
    .clk(clk),
    .we(b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(scan_r[BIDX_W-1:0]),
    .rdata_r(b_rdata)
  );

  // Squared difference of the word and its query entry.
  logic signed [FEAT_W:0] diff;
  logic [FEAT_W:0]        mag;
  logic [2*FEAT_W+1:0]    sq;
  logic [DIST_W:0]        sum;
  assign diff = $signed({fv_r[FEAT_W-1], fv_r}) - $signed({q_rdata[FEAT_W-1], q_rdata});
  assign mag  = diff[FEAT_W] ? (FEAT_W+1)'(-diff) : diff;
  assign sq   = mag * mag;
  logic [2*FEAT_W+1:0] prod_r;
  assign sum  = {1'b0, rdist_r} + (DIST_W+1)'(prod_r);

  // Square root step.
  logic [ROOT_W+2:0] sq_shift;
  logic [ROOT_W+2:0] sq_trial;
  assign sq_shift = {sq_rem_r[ROOT_W:0], sq_v_r[DIST_W-1:DIST_W-2]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};

  // Key write for insertion.
  always_comb begin
    b_we    = 1'b0;
    b_waddr = held_r[BIDX_W-1:0];
    b_wdata = {ins_dist_r, ins_idx_r};
    if (state_r == S_ACC && pend_r && held_r < k_eff) begin
      b_we    = 1'b1;
      b_wdata = {sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0], pcnt_r};
    end else if (state_r == S_IWR && ins_dist_r < sel_key_r[KEY_W-1:IDX_W]) begin
      b_we    = 1'b1;
      b_waddr = sel_i_r;
    end
  end

  logic scan_cand;
  always_comb begin
    if (state_r == S_ISCAN) begin
      scan_cand = !found_r || (b_rdata > sel_key_r);
    end else begin
      scan_cand = (!have_prev_r || b_rdata > prev_key_r) &&
                  (!found_r || b_rdata < sel_key_r);
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= K_W'(3);
      nf_r        <= NF_W'(4);
      pos_r       <= '0;
      pcnt_r      <= '0;
      rdist_r     <= '0;
      held_r      <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Register writes.
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == REG_K) k_r <= cfg_pwdata[K_W-1:0];
        else nf_r <= cfg_pwdata[NF_W-1:0];
      end
      rv_r <= (state_r == S_ISCAN || state_r == S_ESCAN) && scan_r < held_r;
      ri_r <= scan_r[BIDX_W-1:0];
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            fv_r <= in_ch.feature_value;
            if (in_ch.mode == MODE_QUERY || in_ch.mode == MODE_DATA) begin
              pos_r  <= pos_wrap ? '0 : pos_inc[POS_W-1:0];
              pend_r <= pos_wrap;
            end
            if (in_ch.mode == MODE_DATA) begin
              state_r <= S_QRD;
            end else if (in_ch.mode == MODE_FINISH) begin
              if (held_r == '0) begin
                pcnt_r  <= '0;
                rdist_r <= '0;
                pos_r   <= '0;
              end else begin
                emit_r      <= (held_r < k_eff) ? held_r : k_eff;
                e_r         <= '0;
                have_prev_r <= 1'b0;
                found_r     <= 1'b0;
                scan_r      <= '0;
                state_r     <= S_ESCAN;
              end
            end
          end
        end
        S_QRD: begin
          prod_r  <= sq;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (!pend_r) begin
            rdist_r <= sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
            state_r <= S_IDLE;
          end else begin
            rdist_r    <= '0;
            pcnt_r     <= pcnt_r + IDX_W'(1);
            ins_idx_r  <= pcnt_r;
            ins_dist_r <= sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
            if (held_r < k_eff) begin
              held_r  <= held_r + CNT_W'(1);
              state_r <= S_IDLE;
            end else begin
              scan_r  <= '0;
              found_r <= 1'b0;
              state_r <= S_ISCAN;
            end
          end
        end
        S_ISCAN, S_ESCAN: begin
          if (scan_r < held_r) scan_r <= scan_r + CNT_W'(1);
          if (rv_r && scan_cand) begin
            sel_key_r <= b_rdata;
            sel_i_r   <= ri_r;
            found_r   <= 1'b1;
          end
          if (scan_r == held_r && !rv_r) begin
            if (state_r == S_ISCAN) begin
              state_r <= S_IWR;
            end else begin
              prev_key_r  <= sel_key_r;
              have_prev_r <= 1'b1;
              sq_v_r      <= sel_key_r[KEY_W-1:IDX_W];
              sq_rem_r    <= '0;
              sq_root_r   <= '0;
              sq_step_r   <= '0;
              state_r     <= S_SQRT;
            end
          end
        end
        S_IWR: begin
          state_r <= S_IDLE;
        end
        S_SQRT: begin
          sq_v_r <= {sq_v_r[DIST_W-3:0], 2'b00};
          if (sq_shift >= sq_trial) begin
            sq_rem_r  <= sq_shift - sq_trial;
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem_r  <= sq_shift;
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b0};
          end
          sq_step_r <= sq_step_r + 5'd1;
          if (sq_step_r == 5'(ROOT_W - 1)) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= prev_key_r[IDX_W-1:0];
            out_dist_r  <= (sq_shift >= sq_trial) ? {sq_root_r[ROOT_W-2:0], 1'b1}
                                                   : {sq_root_r[ROOT_W-2:0], 1'b0};
            out_last_r  <= (e_r + CNT_W'(1) == emit_r);
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              held_r  <= '0;
              pcnt_r  <= '0;
              rdist_r <= '0;
              pos_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              e_r     <= e_r + CNT_W'(1);
              found_r <= 1'b0;
              scan_r  <= '0;
              state_r <= S_ESCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result word.
  assign out_ch.valid             = out_valid_r;
  assign out_ch.neighbor_index    = out_idx_r;
  assign out_ch.neighbor_distance = out_dist_r;
  assign out_ch.last_result       = out_last_r;

  // Register read-back.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NF) ? 32'(nf_r) : 32'(k_r);

  `KNN_ASSERT_IMP(a_out_blocks_in, clk, rst_n, out_valid_r, !in_ch.ready)
  `KNN_ASSERT_IMP(a_held_bound, clk, rst_n, 1'b1, held_r <= CNT_W'(MAX_NEIGHBORS))
  `KNN_ASSERT_NXT(a_data_busy, clk, rst_n, in_acc && in_ch.mode == MODE_DATA, !in_ch.ready)
endmodule
`default_nettype wire
